@@ src/iee_pkg.sv @@
// Package: shared constants, types and codes for the infix expression evaluator.
package iee_pkg;
  localparam int StackDepth = 32;
  localparam int CountW = $clog2(StackDepth + 1);
  localparam int IndexW = (StackDepth > 1) ? $clog2(StackDepth) : 1;

  localparam logic [1:0] CMD_NUMBER = 2'd0;
  localparam logic [1:0] CMD_LPAREN = 2'd1;
  localparam logic [1:0] CMD_RPAREN = 2'd2;
  localparam logic [1:0] CMD_OPER   = 2'd3;

  localparam logic [3:0] OP_ADD = 4'd0;
  localparam logic [3:0] OP_SUB = 4'd1;
  localparam logic [3:0] OP_MUL = 4'd2;
  localparam logic [3:0] OP_DIV = 4'd3;
  localparam logic [3:0] OP_MOD = 4'd4;
  localparam logic [3:0] OP_LT  = 4'd5;
  localparam logic [3:0] OP_GT  = 4'd6;
  localparam logic [3:0] OP_GE  = 4'd7;
  localparam logic [3:0] OP_LE  = 4'd8;
  localparam logic [3:0] OP_NE  = 4'd9;
  localparam logic [3:0] OP_EQ  = 4'd10;
  localparam logic [3:0] OP_AND = 4'd11;
  localparam logic [3:0] OP_OR  = 4'd12;
  localparam logic [3:0] OP_NOT = 4'd13;
  localparam logic [3:0] OP_LAST_VALID = 4'd13;
  localparam logic [3:0] LPAREN_MARK = 4'd15;

  localparam logic [2:0] ERR_NONE    = 3'd0;
  localparam logic [2:0] ERR_DIVZERO = 3'd1;
  localparam logic [2:0] ERR_OPERAND = 3'd2;
  localparam logic [2:0] ERR_OVERFLW = 3'd3;
  localparam logic [2:0] ERR_PAREN   = 3'd4;

  typedef struct packed {
    logic [3:0]  op;
    logic [31:0] a;
    logic [31:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [31:0] value;
    logic        div_zero;
  } alu_rsp_t;

  function automatic logic [2:0] prec_of(input logic [3:0] op);
    logic [2:0] p;
    p = 3'd0;
    if (op >= OP_MUL && op <= OP_MOD) p = 3'd5;
    else if (op <= OP_SUB) p = 3'd4;
    else if (op >= OP_LT && op <= OP_EQ) p = 3'd3;
    else if (op == OP_AND) p = 3'd2;
    else if (op == OP_OR) p = 3'd1;
    return p;
  endfunction
endpackage

@@ src/iee_if.sv @@
// Interfaces: token and result channels with valid/ready handshake.
interface iee_token_if (input logic clk);
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [3:0]  op_code;
  logic signed [31:0] operand_value;
  logic        last_token;
  modport source (output valid, command, op_code, operand_value, last_token, input ready);
  modport sink (input valid, command, op_code, operand_value, last_token, output ready);
endinterface

interface iee_result_if (input logic clk);
  logic        valid;
  logic        ready;
  logic signed [31:0] answer;
  logic [2:0]  error_code;
  modport source (output valid, answer, error_code, input ready);
  modport sink (input valid, answer, error_code, output ready);
endinterface

@@ src/iee_alu.sv @@
// Shared arithmetic unit: add, multiply, compare combinationally into a registered result, divide bit-serially.
module iee_alu (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  iee_pkg::alu_req_t req,
  output logic              done,
  output iee_pkg::alu_rsp_t rsp
);
  typedef enum logic [1:0] {S_IDLE, S_DIV, S_FIX} state_t;
  state_t      state;
  logic [31:0] rem;
  logic [31:0] quo;
  logic [31:0] dvs;
  logic [5:0]  cnt;
  logic        neg_q;
  logic        neg_r;
  logic        is_mod;
  logic [32:0] trial;
  logic [31:0] rem_shift;
  logic [31:0] comb_val;
  logic signed [31:0] sa;
  logic signed [31:0] sb;

  assign sa = req.a;
  assign sb = req.b;
  assign rem_shift = {rem[30:0], quo[31]};
  assign trial = {1'b0, rem_shift} - {1'b0, dvs};

  always_comb begin
    comb_val = '0;
    unique case (req.op)
      iee_pkg::OP_ADD: comb_val = req.a + req.b;
      iee_pkg::OP_SUB: comb_val = req.a - req.b;
      iee_pkg::OP_MUL: comb_val = req.a * req.b;
      iee_pkg::OP_LT:  comb_val = {31'd0, sa < sb};
      iee_pkg::OP_GT:  comb_val = {31'd0, sa > sb};
      iee_pkg::OP_GE:  comb_val = {31'd0, sa >= sb};
      iee_pkg::OP_LE:  comb_val = {31'd0, sa <= sb};
      iee_pkg::OP_EQ:  comb_val = {31'd0, sa == sb};
      iee_pkg::OP_AND: comb_val = {31'd0, (req.a != 0) && (req.b != 0)};
      iee_pkg::OP_OR:  comb_val = {31'd0, (req.a != 0) || (req.b != 0)};
      default:         comb_val = {31'd0, sa != sb};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            if (req.op == iee_pkg::OP_DIV || req.op == iee_pkg::OP_MOD) begin
              if (req.b == 0) begin
                rsp.div_zero <= 1'b1;
                rsp.value <= '0;
                done <= 1'b1;
              end else begin
                // operate on magnitudes, restore signs at the end
                quo <= req.a[31] ? -req.a : req.a;
                dvs <= req.b[31] ? -req.b : req.b;
                rem <= '0;
                cnt <= 6'd32;
                neg_q <= req.a[31] ^ req.b[31];
                neg_r <= req.a[31];
                is_mod <= (req.op == iee_pkg::OP_MOD);
                done <= 1'b0;
                state <= S_DIV;
              end
            end else begin
              rsp.div_zero <= 1'b0;
              rsp.value <= comb_val;
              done <= 1'b1;
            end
          end else begin
            done <= 1'b0;
          end
        end
        S_DIV: begin
          done <= 1'b0;
          if (!trial[32]) begin
            rem <= trial[31:0];
            quo <= {quo[30:0], 1'b1};
          end else begin
            rem <= rem_shift;
            quo <= {quo[30:0], 1'b0};
          end
          cnt <= cnt - 6'd1;
          if (cnt == 6'd1) state <= S_FIX;
        end
        default: begin
          rsp.div_zero <= 1'b0;
          if (is_mod) rsp.value <= neg_r ? -rem : rem;
          else rsp.value <= neg_q ? -quo : quo;
          done <= 1'b1;
          state <= S_IDLE;
        end
      endcase
    end
  end
endmodule

@@ src/infix_expression_evaluator.sv @@
// Top level: token sequencer, operator and operand stacks, result register.
// Tokens arrive one at a time; ready is high only while the sequencer is idle.
// An operand or left paren is accepted, then dispatched. An operator is
// pushed at once when the operator stack is empty, else the top operator
// is read and checked first; a right paren reads it when one is pending.
// Each operator popped reads the operator stack, reads both operands and
// runs the ALU; / and % also wait on the 32-step bit-serial divider in the
// shared ALU. The last token then drains the operator stack the same way,
// posts one result holding answer and error_code, and holds there while
// an earlier result still waits. The first error sticks and later tokens
// are dropped until the last token. The result register lets the next
// token be taken while a result waits.
module infix_expression_evaluator (
  input logic clk,
  input logic rst,
  iee_token_if.sink    tok,
  iee_result_if.source res
);
  localparam int CW = iee_pkg::CountW;
  localparam int IW = iee_pkg::IndexW;
  localparam logic [CW-1:0] Depth = CW'(iee_pkg::StackDepth);

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_OPR_RD, S_OPR_CHK, S_VAL_RD, S_VAL_WAIT, S_ALU, S_ALU_WAIT,
    S_PUSH_OP, S_FINISH, S_EMIT_RD, S_EMIT
  } state_t;

  state_t state;
  logic [3:0]  op_mem [iee_pkg::StackDepth];
  logic [31:0] val_mem [iee_pkg::StackDepth];
  logic [CW-1:0] op_cnt;
  logic [CW-1:0] val_cnt;
  logic [2:0]  err;
  logic [1:0]  cmd;
  logic [3:0]  opc;
  logic [31:0] val;
  logic        last;
  logic [3:0]  top_op;
  logic [31:0] rd_a;
  logic [31:0] rd_b;
  logic        val_rd_hi;
  logic [IW-1:0] op_rd_idx;
  logic [IW-1:0] val_rd_idx;
  logic        alu_start;
  logic        alu_done;
  iee_pkg::alu_req_t alu_req;
  iee_pkg::alu_rsp_t alu_rsp;
  logic [2:0]  err_next;

  assign tok.ready = (state == S_IDLE);
  assign alu_req.op = top_op;
  assign alu_req.a = rd_a;
  assign alu_req.b = rd_b;
  assign alu_start = (state == S_ALU);

  iee_alu u_alu (
    .clk(clk), .rst(rst), .start(alu_start), .req(alu_req), .done(alu_done), .rsp(alu_rsp)
  );

  // stack memories: one read port each, registered data; hold top_op
  // through the whole reduction
  always_ff @(posedge clk) begin
    if (state == S_OPR_RD) top_op <= op_mem[op_rd_idx];
    if (val_rd_hi) rd_b <= val_mem[val_rd_idx];
    else rd_a <= val_mem[val_rd_idx];
  end

  always_comb begin
    op_rd_idx = IW'(op_cnt - CW'(1));
    val_rd_hi = (state == S_OPR_CHK) || (state == S_EMIT_RD);
    val_rd_idx = val_rd_hi ? IW'(val_cnt - CW'(1)) : IW'(val_cnt - CW'(2));
    err_next = err;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      op_cnt <= '0;
      val_cnt <= '0;
      err <= iee_pkg::ERR_NONE;
      res.valid <= 1'b0;
    end else begin
      if (res.valid && res.ready && state != S_EMIT) res.valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (tok.valid && tok.ready) begin
            cmd <= tok.command;
            opc <= tok.op_code;
            val <= tok.operand_value;
            last <= tok.last_token;
            state <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          if (err != iee_pkg::ERR_NONE) begin
            state <= last ? S_FINISH : S_IDLE;
          end else begin
            unique case (cmd)
              iee_pkg::CMD_NUMBER: begin
                if (val_cnt >= Depth) err <= iee_pkg::ERR_OVERFLW;
                else begin
                  val_mem[IW'(val_cnt)] <= val;
                  val_cnt <= val_cnt + CW'(1);
                end
                state <= last ? S_FINISH : S_IDLE;
              end
              iee_pkg::CMD_LPAREN: begin
                if (op_cnt >= Depth) err <= iee_pkg::ERR_OVERFLW;
                else begin
                  op_mem[IW'(op_cnt)] <= iee_pkg::LPAREN_MARK;
                  op_cnt <= op_cnt + CW'(1);
                end
                state <= last ? S_FINISH : S_IDLE;
              end
              iee_pkg::CMD_RPAREN: begin
                if (op_cnt == 0) begin
                  err <= iee_pkg::ERR_PAREN;
                  state <= last ? S_FINISH : S_IDLE;
                end else state <= S_OPR_RD;
              end
              default: begin
                if (opc > iee_pkg::OP_LAST_VALID) state <= last ? S_FINISH : S_IDLE;
                else if (op_cnt == 0) state <= S_PUSH_OP;
                else state <= S_OPR_RD;
              end
            endcase
          end
        end
        S_OPR_RD: state <= S_OPR_CHK;  // top_op read in flight
        S_OPR_CHK: begin
          // top_op valid; rd_b read issued this cycle
          if (cmd == iee_pkg::CMD_RPAREN) begin
            op_cnt <= op_cnt - CW'(1);
            if (top_op == iee_pkg::LPAREN_MARK) state <= last ? S_FINISH : S_IDLE;
            else state <= S_VAL_RD;
          end else if (cmd == iee_pkg::CMD_OPER) begin
            if (top_op == iee_pkg::LPAREN_MARK ||
                iee_pkg::prec_of(top_op) < iee_pkg::prec_of(opc)) begin
              state <= S_PUSH_OP;
            end else begin
              op_cnt <= op_cnt - CW'(1);
              state <= S_VAL_RD;
            end
          end else begin
            // end-of-expression drain
            op_cnt <= op_cnt - CW'(1);
            if (top_op == iee_pkg::LPAREN_MARK) begin
              err <= iee_pkg::ERR_PAREN;
              state <= S_EMIT;
            end else state <= S_VAL_RD;
          end
        end
        S_VAL_RD: begin
          // rd_a read issued; need two operands
          if (val_cnt < CW'(2)) begin
            err <= iee_pkg::ERR_OPERAND;
            state <= (cmd == iee_pkg::CMD_NUMBER) ? S_EMIT : (last ? S_FINISH : S_IDLE);
          end else state <= S_VAL_WAIT;
        end
        S_VAL_WAIT: state <= S_ALU;
        S_ALU: state <= S_ALU_WAIT;
        S_ALU_WAIT: begin
          if (alu_done) begin
            if (alu_rsp.div_zero) begin
              err <= iee_pkg::ERR_DIVZERO;
              state <= (cmd == iee_pkg::CMD_NUMBER) ? S_EMIT : (last ? S_FINISH : S_IDLE);
            end else begin
              val_mem[IW'(val_cnt - CW'(2))] <= alu_rsp.value;
              val_cnt <= val_cnt - CW'(1);
              if (cmd == iee_pkg::CMD_OPER) begin
                state <= (op_cnt == 0) ? S_PUSH_OP : S_OPR_RD;
              end else if (op_cnt == 0) begin
                if (cmd == iee_pkg::CMD_RPAREN) begin
                  err <= iee_pkg::ERR_PAREN;
                  state <= last ? S_FINISH : S_IDLE;
                end else state <= S_FINISH;
              end else state <= S_OPR_RD;
            end
          end
        end
        S_PUSH_OP: begin
          if (op_cnt >= Depth) err <= iee_pkg::ERR_OVERFLW;
          else begin
            op_mem[IW'(op_cnt)] <= opc;
            op_cnt <= op_cnt + CW'(1);
          end
          state <= last ? S_FINISH : S_IDLE;
        end
        S_FINISH: begin
          // drain pending operators; cmd NUMBER marks the drain pass
          cmd <= iee_pkg::CMD_NUMBER;
          if (err == iee_pkg::ERR_NONE && op_cnt != 0) state <= S_OPR_RD;
          else begin
            if (err == iee_pkg::ERR_NONE && val_cnt == 0) err <= iee_pkg::ERR_OPERAND;
            state <= S_EMIT_RD;
          end
        end
        S_EMIT_RD: state <= S_EMIT;  // rd_b holds top operand next cycle
        default: begin
          if (!res.valid || res.ready) begin
            res.valid <= 1'b1;
            res.error_code <= err_next;
            res.answer <= (err_next == iee_pkg::ERR_NONE) ? rd_b : '0;
            err <= iee_pkg::ERR_NONE;
            op_cnt <= '0;
            val_cnt <= '0;
            state <= S_IDLE;
          end
        end
      endcase
    end
  end
endmodule

@@ sim/tb_top.sv @@
// Testbench for the infix expression evaluator: table-driven and random token streams.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NumRandomItems = 600;
  localparam int IdleLimit = 20000;
  localparam int DrainCycles = 200;
  localparam int MaxReported = 10;

  // One token as it is queued for the sender. A token may carry its
  // own expected answer; every other item is scored by the predictor.
  typedef struct {
    logic [1:0]  cmd;
    logic [3:0]  op;
    logic [31:0] val;
    bit          last;
    bit          typed;
    logic [31:0] ans;
    logic [2:0]  err;
  } token_t;

  typedef struct {
    logic [31:0] ans;
    logic [2:0]  err;
  } answer_t;

  logic clk;
  logic rst;

  iee_token_if  tok (clk);
  iee_result_if res (clk);

  infix_expression_evaluator dut (
    .clk(clk),
    .rst(rst),
    .tok(tok),
    .res(res)
  );

  // Clock: 10 ns period.
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  token_t  token_q[$];
  answer_t answer_q[$];
  int      mismatches = 0;
  int      results_seen = 0;
  int      idle_cycles = 0;
  int      hold_cycles = 0;
  bit      hold_done = 1'b0;

  // ---------------------------------------------------------------------
  // Evaluator shadow: operator and operand stacks, counts, sticky error.
  // ---------------------------------------------------------------------
  logic [3:0]  opr_stack[iee_pkg::StackDepth];
  logic [31:0] val_stack[iee_pkg::StackDepth];
  int          opr_cnt;
  int          val_cnt;
  logic [2:0]  sticky;

  function automatic int rank(input logic [3:0] op);
    case (op)
      iee_pkg::OP_MUL, iee_pkg::OP_DIV, iee_pkg::OP_MOD: return 5;
      iee_pkg::OP_ADD, iee_pkg::OP_SUB: return 4;
      iee_pkg::OP_LT, iee_pkg::OP_GT, iee_pkg::OP_GE, iee_pkg::OP_LE, iee_pkg::OP_NE,
      iee_pkg::OP_EQ: return 3;
      iee_pkg::OP_AND: return 2;
      iee_pkg::OP_OR: return 1;
      default: return 0;
    endcase
  endfunction

  function automatic void flag(input logic [2:0] e);
    if (sticky == iee_pkg::ERR_NONE) sticky = e;
  endfunction

  function automatic void clear_state();
    opr_cnt = 0;
    val_cnt = 0;
    sticky = iee_pkg::ERR_NONE;
  endfunction

  // Pop two operands, push the result of op on them.
  function automatic void reduce(input logic [3:0] op);
    longint a, b, q;
    logic [31:0] ua, ub, r;
    if (val_cnt < 2) begin
      flag(iee_pkg::ERR_OPERAND);
      return;
    end
    ub = val_stack[val_cnt-1];
    ua = val_stack[val_cnt-2];
    a = longint'($signed(ua));
    b = longint'($signed(ub));
    r = '0;
    case (op)
      iee_pkg::OP_ADD: r = ua + ub;
      iee_pkg::OP_SUB: r = ua - ub;
      iee_pkg::OP_MUL: r = ua * ub;
      iee_pkg::OP_DIV, iee_pkg::OP_MOD: begin
        if (b == 0) begin
          flag(iee_pkg::ERR_DIVZERO);
          return;
        end
        // 64-bit math keeps most-negative over minus one well defined.
        q = (op == iee_pkg::OP_DIV) ? a / b : a % b;
        r = q[31:0];
      end
      iee_pkg::OP_LT: r = {31'd0, a < b};
      iee_pkg::OP_GT: r = {31'd0, a > b};
      iee_pkg::OP_GE: r = {31'd0, a >= b};
      iee_pkg::OP_LE: r = {31'd0, a <= b};
      iee_pkg::OP_EQ: r = {31'd0, a == b};
      iee_pkg::OP_AND: r = {31'd0, (a != 0) && (b != 0)};
      iee_pkg::OP_OR: r = {31'd0, (a != 0) || (b != 0)};
      default: r = {31'd0, a != b};  // not-equal and "not"
    endcase
    val_cnt--;
    val_stack[val_cnt-1] = r;
  endfunction

  function automatic void take_token(input logic [1:0] cmd, input logic [3:0] op,
                                     input logic [31:0] val);
    logic [3:0] top;
    case (cmd)
      iee_pkg::CMD_NUMBER: begin
        if (val_cnt >= iee_pkg::StackDepth) flag(iee_pkg::ERR_OVERFLW);
        else val_stack[val_cnt++] = val;
      end
      iee_pkg::CMD_LPAREN: begin
        if (opr_cnt >= iee_pkg::StackDepth) flag(iee_pkg::ERR_OVERFLW);
        else opr_stack[opr_cnt++] = iee_pkg::LPAREN_MARK;
      end
      iee_pkg::CMD_RPAREN: begin
        forever begin
          if (opr_cnt == 0) begin
            flag(iee_pkg::ERR_PAREN);
            return;
          end
          top = opr_stack[--opr_cnt];
          if (top == iee_pkg::LPAREN_MARK) return;
          reduce(top);
          if (sticky != iee_pkg::ERR_NONE) return;
        end
      end
      default: begin
        if (op > iee_pkg::OP_LAST_VALID) return;
        while (opr_cnt > 0) begin
          top = opr_stack[opr_cnt-1];
          if (top == iee_pkg::LPAREN_MARK || rank(top) < rank(op)) break;
          opr_cnt--;
          reduce(top);
          if (sticky != iee_pkg::ERR_NONE) return;
        end
        if (opr_cnt >= iee_pkg::StackDepth) flag(iee_pkg::ERR_OVERFLW);
        else opr_stack[opr_cnt++] = op;
      end
    endcase
  endfunction

  // Advance the shadow by one accepted token; queue an answer on the last one.
  function automatic void score_token(input token_t t);
    logic [3:0] top;
    answer_t a;
    if (sticky == iee_pkg::ERR_NONE) take_token(t.cmd, t.op, t.val);
    if (!t.last) return;
    while (sticky == iee_pkg::ERR_NONE && opr_cnt > 0) begin
      top = opr_stack[--opr_cnt];
      if (top == iee_pkg::LPAREN_MARK) begin
        flag(iee_pkg::ERR_PAREN);
        break;
      end
      reduce(top);
    end
    if (sticky == iee_pkg::ERR_NONE && val_cnt == 0) flag(iee_pkg::ERR_OPERAND);
    a.err = sticky;
    a.ans = (sticky == iee_pkg::ERR_NONE) ? val_stack[val_cnt-1] : 32'd0;
    if (t.typed) begin
      a.ans = t.ans;
      a.err = t.err;
    end
    answer_q.insert(answer_q.size(), a);
    clear_state();
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus builders
  // ---------------------------------------------------------------------
  function automatic void put(input logic [1:0] cmd, input logic [3:0] op,
                              input logic [31:0] val, input bit last);
    token_t t;
    t.cmd = cmd;
    t.op = op;
    t.val = val;
    t.last = last;
    t.typed = 1'b0;
    t.ans = '0;
    t.err = iee_pkg::ERR_NONE;
    token_q.insert(token_q.size(), t);
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return 32'($signed($urandom_range(0, 18)) - 9);
      5: begin
        case ($urandom_range(0, 3))
          0: return 32'h8000_0000;
          1: return 32'h7fff_ffff;
          2: return 32'hffff_ffff;
          default: return 32'd0;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  // Well-formed expression: term (op term)*, terms nest in parentheses.
  function automatic void build_expr(input int lvl);
    int n;
    n = $urandom_range(1, 4);
    for (int i = 0; i < n; i++) begin
      if (i > 0) put(iee_pkg::CMD_OPER, 4'($urandom_range(0, 13)), $urandom, 1'b0);
      if (lvl < 3 && $urandom_range(0, 3) == 0) begin
        put(iee_pkg::CMD_LPAREN, 4'($urandom), $urandom, 1'b0);
        build_expr(lvl + 1);
        put(iee_pkg::CMD_RPAREN, 4'($urandom), $urandom, 1'b0);
      end else begin
        put(iee_pkg::CMD_NUMBER, 4'($urandom), pick_value(), 1'b0);
      end
    end
  endfunction

  // Directed rows: answers typed in where they are obvious, else predicted.
  token_t directed[] = '{
    '{iee_pkg::CMD_NUMBER, iee_pkg::OP_ADD, 32'd5, 1, 1, 32'd5, iee_pkg::ERR_NONE},
    '{iee_pkg::CMD_NUMBER, iee_pkg::OP_ADD, 32'h7fff_ffff, 1, 1, 32'h7fff_ffff,
      iee_pkg::ERR_NONE},
    '{iee_pkg::CMD_NUMBER, iee_pkg::OP_ADD, 32'h8000_0000, 1, 1, 32'h8000_0000,
      iee_pkg::ERR_NONE},
    '{iee_pkg::CMD_OPER,   iee_pkg::OP_ADD, 32'd0, 1, 1, 32'd0, iee_pkg::ERR_OPERAND},
    '{iee_pkg::CMD_NUMBER, iee_pkg::OP_ADD, 32'd7, 0, 0, 32'd0, iee_pkg::ERR_NONE},
    '{iee_pkg::CMD_OPER,   iee_pkg::OP_DIV, 32'd0, 0, 0, 32'd0, iee_pkg::ERR_NONE},
    '{iee_pkg::CMD_NUMBER, iee_pkg::OP_ADD, 32'd0, 1, 1, 32'd0, iee_pkg::ERR_DIVZERO},
    '{iee_pkg::CMD_NUMBER, iee_pkg::OP_ADD, 32'h8000_0000, 0, 0, 32'd0, iee_pkg::ERR_NONE},
    '{iee_pkg::CMD_OPER,   iee_pkg::OP_DIV, 32'd0, 0, 0, 32'd0, iee_pkg::ERR_NONE},
    '{iee_pkg::CMD_NUMBER, iee_pkg::OP_ADD, 32'hffff_ffff, 1, 1, 32'h8000_0000,
      iee_pkg::ERR_NONE},
    '{iee_pkg::CMD_NUMBER, iee_pkg::OP_ADD, 32'h8000_0000, 0, 0, 32'd0, iee_pkg::ERR_NONE},
    '{iee_pkg::CMD_OPER,   iee_pkg::OP_MOD, 32'd0, 0, 0, 32'd0, iee_pkg::ERR_NONE},
    '{iee_pkg::CMD_NUMBER, iee_pkg::OP_ADD, 32'hffff_ffff, 1, 1, 32'd0, iee_pkg::ERR_NONE},
    '{iee_pkg::CMD_RPAREN, iee_pkg::OP_ADD, 32'd0, 1, 1, 32'd0, iee_pkg::ERR_PAREN},
    '{iee_pkg::CMD_LPAREN, iee_pkg::OP_ADD, 32'd0, 0, 0, 32'd0, iee_pkg::ERR_NONE},
    '{iee_pkg::CMD_NUMBER, iee_pkg::OP_ADD, 32'd1, 1, 1, 32'd0, iee_pkg::ERR_PAREN},
    // unknown operators are skipped; the extra operand below the top is lost
    '{iee_pkg::CMD_NUMBER, iee_pkg::OP_ADD, 32'd3, 0, 0, 32'd0, iee_pkg::ERR_NONE},
    '{iee_pkg::CMD_OPER,   4'd14,           32'd0, 0, 0, 32'd0, iee_pkg::ERR_NONE},
    '{iee_pkg::CMD_OPER,   4'd15,           32'd0, 0, 0, 32'd0, iee_pkg::ERR_NONE},
    '{iee_pkg::CMD_NUMBER, iee_pkg::OP_ADD, 32'd4, 1, 1, 32'd4, iee_pkg::ERR_NONE},
    // first error wins: a divide by zero before an unmatched paren
    '{iee_pkg::CMD_NUMBER, iee_pkg::OP_ADD, 32'd9, 0, 0, 32'd0, iee_pkg::ERR_NONE},
    '{iee_pkg::CMD_OPER,   iee_pkg::OP_MOD, 32'd0, 0, 0, 32'd0, iee_pkg::ERR_NONE},
    '{iee_pkg::CMD_NUMBER, iee_pkg::OP_ADD, 32'd0, 0, 0, 32'd0, iee_pkg::ERR_NONE},
    '{iee_pkg::CMD_OPER,   iee_pkg::OP_ADD, 32'd0, 0, 0, 32'd0, iee_pkg::ERR_NONE},
    '{iee_pkg::CMD_RPAREN, iee_pkg::OP_ADD, 32'd0, 1, 1, 32'd0, iee_pkg::ERR_DIVZERO}
  };

  function automatic void build_stimulus();
    int kind;
    foreach (directed[i]) token_q.insert(token_q.size(), directed[i]);
    // every operator once, chained: precedence decides the reduction order
    for (int op = 0; op <= 13; op++) begin
      put(iee_pkg::CMD_NUMBER, iee_pkg::OP_ADD, 32'(op * 3 - 7), 1'b0);
      put(iee_pkg::CMD_OPER, 4'(op), 32'd0, 1'b0);
    end
    put(iee_pkg::CMD_NUMBER, iee_pkg::OP_ADD, 32'd2, 1'b1);
    // full operator stack: one left paren too many
    for (int i = 0; i <= iee_pkg::StackDepth; i++)
      put(iee_pkg::CMD_LPAREN, iee_pkg::OP_ADD, 32'd0, 1'b0);
    put(iee_pkg::CMD_NUMBER, iee_pkg::OP_ADD, 32'd1, 1'b1);
    token_q[token_q.size()-1].typed = 1'b1;
    token_q[token_q.size()-1].err = iee_pkg::ERR_OVERFLW;
    // full operand stack
    for (int i = 0; i <= iee_pkg::StackDepth; i++)
      put(iee_pkg::CMD_NUMBER, iee_pkg::OP_ADD, 32'(i), 1'b0);
    put(iee_pkg::CMD_NUMBER, iee_pkg::OP_ADD, 32'd0, 1'b1);

    while (token_q.size() < NumRandomItems) begin
      kind = $urandom_range(0, 9);
      if (kind < 7) begin
        build_expr(0);
        if (kind == 0 && token_q.size() > 0)
          token_q.delete(token_q.size() - 1);  // broken tail
        put(iee_pkg::CMD_NUMBER, 4'($urandom), pick_value(), 1'b0);
        token_q[token_q.size()-1].last = 1'b1;
        if (kind == 1) token_q[token_q.size()-1].cmd = iee_pkg::CMD_RPAREN;
      end else begin
        // noise: raw tokens over the full field ranges
        for (int i = $urandom_range(1, 8); i > 0; i--)
          put(2'($urandom), 4'($urandom), $urandom, 1'b0);
        put(2'($urandom), 4'($urandom), $urandom, 1'b1);
      end
    end
  endfunction

  // ---------------------------------------------------------------------
  // Sender: bursts of random length separated by random gaps.
  // ---------------------------------------------------------------------
  int burst_left = 0;
  int gap_left = 0;

  initial begin
    tok.valid = 1'b0;
    tok.command = iee_pkg::CMD_NUMBER;
    tok.op_code = iee_pkg::OP_ADD;
    tok.operand_value = '0;
    tok.last_token = 1'b0;
    res.ready = 1'b0;
    rst = 1'b1;
  end

  always @(posedge clk) begin
    if (rst) begin
      tok.valid <= 1'b0;
    end else begin
      if (tok.valid && tok.ready) begin
        score_token(token_q.pop_front());
      end
      if (!tok.valid || tok.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          tok.valid <= 1'b0;
        end else if (token_q.size() > 0) begin
          tok.valid <= 1'b1;
          tok.command <= token_q[0].cmd;
          tok.op_code <= token_q[0].op;
          tok.operand_value <= token_q[0].val;
          tok.last_token <= token_q[0].last;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 60);
          end else begin
            burst_left--;
          end
        end else begin
          tok.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Receiver: stall pattern steps through four modes by rx_cycle; one long
  // hold-off keeps the result register full so the input stalls behind it.
  // ---------------------------------------------------------------------
  int rx_cycle = 0;

  always @(posedge clk) begin
    if (rst) begin
      hold_cycles <= 0;
    end else if (!hold_done && results_seen == 20) begin
      hold_done <= 1'b1;
      hold_cycles <= 3000;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
    end
  end

  always @(posedge clk) begin
    answer_t exp_a;
    bit      rdy;
    if (rst) begin
      res.ready <= 1'b0;
    end else begin
      if (res.valid && res.ready) begin
        results_seen++;
        if (answer_q.size() == 0) begin
          mismatches++;
          if (mismatches <= MaxReported)
            $display("unexpected result: answer %0d error %0d", res.answer, res.error_code);
        end else begin
          exp_a = answer_q.pop_front();
          if (res.answer !== exp_a.ans || res.error_code !== exp_a.err) begin
            mismatches++;
            if (mismatches <= MaxReported)
              $display("result %0d: expected answer %0d error %0d, got answer %0d error %0d",
                       results_seen, $signed(exp_a.ans), exp_a.err, res.answer,
                       res.error_code);
          end
        end
      end
      rx_cycle++;
      case ((rx_cycle / 256) % 4)
        0: rdy = 1'b1;
        1: rdy = ($urandom_range(0, 1) == 1);
        2: rdy = ($urandom_range(0, 3) == 0);
        default: rdy = ($urandom_range(0, 7) != 0);
      endcase
      if (hold_cycles > 1 || (!hold_done && results_seen == 20)) rdy = 1'b0;
      res.ready <= rdy;
    end
  end

  // Watchdog: stop if nothing moves on either channel for too long.
  always @(posedge clk) begin
    if (rst || (tok.valid && tok.ready) || (res.valid && res.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("infix_expression_evaluator verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Main sequence: reset, send everything, drain, report.
  initial begin
    build_stimulus();
    clear_state();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    wait (token_q.size() == 0);
    wait (answer_q.size() == 0);
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0 && answer_q.size() == 0) begin
      $display("infix_expression_evaluator verification clean");
    end else begin
      $display("infix_expression_evaluator verification failed");
    end
    $finish;
  end
endmodule
